/* hdl/ipd_pkg.sv */
// Shared types, codes and nibble tables for the ISO 9796-1 pad decoder.
package ipd_pkg;

    localparam int KEY_W     = 13;
    localparam int KEY_ROUND = 13;
    localparam int T_SHIFT   = 4;
    localparam int T_W       = KEY_W + 1 - T_SHIFT;
    localparam int TWO_T_W   = T_W + 1;
    localparam int REC_LEN_W = 9;

    localparam logic [KEY_W-1:0]     KEY_BITS_RESET = 13'd1024;
    localparam logic [REC_LEN_W-1:0] REC_LEN_MAX    = '1;
    localparam logic [3:0]           TAIL_NIBBLE    = 4'h6;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_READ   = 1'b1
    } rsp_kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NIBBLE = 2'd1,
        ST_SECOND = 2'd2,
        ST_LENGTH = 2'd3
    } dec_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_TAIL_FIX,
        S_SCAN_HI,
        S_SCAN_LO,
        S_SCAN_CHK,
        S_FINISH,
        S_STATUS,
        S_READ
    } ipd_state_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_in;
        logic       is_last;
        logic [7:0] read_index;
    } ipd_req_t;

    typedef struct packed {
        logic                 result_kind;
        logic [1:0]           status;
        logic [REC_LEN_W-1:0] recovered_length;
        logic [7:0]           pad_value;
        logic [7:0]           data_out;
        logic                 read_ok;
    } ipd_rsp_t;

    localparam logic [3:0] SHADOW_NIB [16] = '{
        4'he, 4'h3, 4'h5, 4'h8, 4'h9, 4'h4, 4'h2, 4'hf,
        4'h0, 4'hd, 4'hb, 4'h6, 4'h7, 4'ha, 4'hc, 4'h1
    };

    localparam logic [3:0] INVERSE_NIB [16] = '{
        4'h8, 4'hf, 4'h6, 4'h1, 4'h5, 4'h2, 4'hb, 4'hc,
        4'h3, 4'h4, 4'hd, 4'ha, 4'he, 4'h9, 4'h0, 4'h7
    };

    function automatic logic [7:0] shadow_byte(input logic [7:0] v);
        return {SHADOW_NIB[v[7:4]], SHADOW_NIB[v[3:0]]};
    endfunction

endpackage

/* hdl/ipd_mem.sv */
// Block byte store: one write port, one read port, registered read data.
module ipd_mem #(
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/ipd_seq.sv */
// Load/decode/read sequencer working on the block store.
module ipd_seq #(
    parameter int MAX_BLOCK_BYTES = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  ipd_pkg::ipd_req_t                  req_item,
    input  logic [ipd_pkg::KEY_W-1:0]          key_bits,
    output logic                               res_valid,
    input  logic                               res_ready,
    output ipd_pkg::ipd_rsp_t                  res_item,
    output logic                               mem_wr_en,
    output logic [$clog2(MAX_BLOCK_BYTES)-1:0] mem_wr_addr,
    output logic [7:0]                         mem_wr_data,
    output logic                               mem_rd_en,
    output logic [$clog2(MAX_BLOCK_BYTES)-1:0] mem_rd_addr,
    input  logic [7:0]                         mem_rd_data
);

    import ipd_pkg::*;

    localparam int AW = $clog2(MAX_BLOCK_BYTES);
    localparam int CW = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int LW = (CW > TWO_T_W) ? CW : TWO_T_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(MAX_BLOCK_BYTES);

    ipd_state_t state_reg, state_next;

    logic [CW-1:0]        load_count_reg, load_count_next;
    logic [REC_LEN_W-1:0] out_length_reg, out_length_next;
    dec_status_t          last_status_reg, last_status_next;
    logic [AW-1:0]        boundary_pos_reg, boundary_pos_next;

    logic [7:0]    first_byte_reg, first_byte_next;
    logic          base_reg, base_next;
    logic [CW-1:0] len_reg, len_next;
    logic [7:0]    tail_byte_reg, tail_byte_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [T_W-1:0] pairs_reg, pairs_next;
    logic [7:0]    hi_byte_reg, hi_byte_next;
    logic          found_reg, found_next;
    logic [7:0]    x_reg, x_next;
    logic [AW-1:0] bnd_reg, bnd_next;
    logic [7:0]    pad_reg, pad_next;
    logic          read_ok_reg, read_ok_next;

    logic                 req_fire;
    logic                 is_load;
    logic                 is_read;
    logic                 lc_room;
    logic [CW-1:0]        lc_inc;
    logic [7:0]           first_now;
    logic                 lead_zero;
    logic [CW-1:0]        len_start;
    logic [KEY_W:0]       key_sum;
    logic [T_W-1:0]       t_val;
    logic [TWO_T_W-1:0]   two_t;
    logic [CW-1:0]        tail_pos;
    logic [AW-1:0]        tail_addr;
    logic                 nib_bad;
    logic                 len_short;
    logic [7:0]           fix_byte;
    logic [AW-1:0]        hi_addr;
    logic [AW-1:0]        next_hi_addr;
    logic [7:0]           x_now;
    logic                 hit;
    logic                 last_pair;
    logic [CW-1:0]        span;
    logic [LW-1:0]        half;
    logic [REC_LEN_W-1:0] rec_len_now;
    logic [AW-1:0]        rd_idx_addr;
    logic                 read_ok_now;
    logic                 dec_ok;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign is_load   = (req_item.req_type == REQ_LOAD);
    assign is_read   = (req_item.req_type == REQ_READ);

    assign lc_room   = (load_count_reg < DEPTH_C);
    assign lc_inc    = lc_room ? load_count_reg + CW'(1) : load_count_reg;
    assign first_now = (load_count_reg == '0) ? req_item.data_in : first_byte_reg;
    assign lead_zero = (first_now == 8'h00);
    assign len_start = lc_inc - CW'(lead_zero);

    // t = (key_bits + 13) / 16
    assign key_sum = {1'b0, key_bits} + (KEY_W + 1)'(KEY_ROUND);
    assign t_val   = key_sum[KEY_W:T_SHIFT];
    assign two_t   = {t_val, 1'b0};

    assign tail_pos  = len_reg + CW'(base_reg) - CW'(1);
    assign tail_addr = tail_pos[AW-1:0];
    assign nib_bad   = (mem_rd_data[3:0] != TAIL_NIBBLE);
    assign len_short = (len_reg < CW'(2)) || (LW'(len_reg) < LW'(two_t));
    assign fix_byte  = {INVERSE_NIB[mem_rd_data[7:4]], tail_byte_reg[7:4]};

    // pos_reg is the high byte of the pair, relative to the block start
    assign hi_addr      = AW'(base_reg) + pos_reg;
    assign next_hi_addr = hi_addr - AW'(2);
    assign x_now        = mem_rd_data ^ shadow_byte(hi_byte_reg);
    // the first pair (high byte at position 1) is excluded, so that pair never flags
    assign hit          = (x_now != 8'h00) && (pos_reg != AW'(1));
    assign last_pair    = (pairs_reg == T_W'(1));

    assign span        = len_reg - CW'(bnd_reg);
    assign half        = LW'(span >> 1);
    assign rec_len_now = (half > LW'(REC_LEN_MAX)) ? REC_LEN_MAX : half[REC_LEN_W-1:0];

    assign rd_idx_addr = boundary_pos_reg + AW'(1) + AW'({req_item.read_index, 1'b0});
    assign read_ok_now = ({1'b0, req_item.read_index} < out_length_reg);
    assign dec_ok      = (last_status_reg == ST_OK);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && is_read)
                begin
                    state_next = S_READ;
                end
                else if (req_fire && req_item.is_last)
                begin
                    state_next = (len_start == '0) ? S_STATUS : S_TAIL_RD;
                end
            end
            S_TAIL_RD:
            begin
                state_next = S_TAIL_CHK;
            end
            S_TAIL_CHK:
            begin
                state_next = (nib_bad || len_short) ? S_STATUS : S_TAIL_FIX;
            end
            S_TAIL_FIX:
            begin
                state_next = (t_val == '0) ? S_FINISH : S_SCAN_HI;
            end
            S_SCAN_HI:
            begin
                state_next = S_SCAN_LO;
            end
            S_SCAN_LO:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (hit && found_reg)
                begin
                    state_next = S_STATUS;
                end
                else if (last_pair)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_LO;
                end
            end
            S_FINISH:
            begin
                state_next = S_STATUS;
            end
            S_STATUS, S_READ:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory port and result outputs
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = 8'h00;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        res_valid   = 1'b0;
        res_item    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_wr_en   = req_fire && is_load && lc_room;
                mem_wr_addr = load_count_reg[AW-1:0];
                mem_wr_data = req_item.data_in;
                mem_rd_en   = req_fire && is_read && read_ok_now;
                mem_rd_addr = rd_idx_addr;
            end
            S_TAIL_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = tail_addr;
            end
            S_TAIL_CHK:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = tail_addr - AW'(1);
            end
            S_TAIL_FIX:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = tail_addr;
                mem_wr_data = fix_byte;
            end
            S_SCAN_HI:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = hi_addr;
            end
            S_SCAN_LO:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = hi_addr - AW'(1);
            end
            S_SCAN_CHK:
            begin
                mem_rd_en   = !last_pair;
                mem_rd_addr = next_hi_addr;
            end
            S_FINISH:
            begin
                mem_rd_en = 1'b0;
            end
            S_STATUS:
            begin
                res_valid                 = 1'b1;
                res_item.result_kind      = KIND_STATUS;
                res_item.status           = last_status_reg;
                res_item.recovered_length = dec_ok ? out_length_reg : '0;
                res_item.pad_value        = dec_ok ? pad_reg : 8'h00;
            end
            S_READ:
            begin
                res_valid                 = 1'b1;
                res_item.result_kind      = KIND_READ;
                res_item.status           = last_status_reg;
                res_item.recovered_length = out_length_reg;
                res_item.data_out         = read_ok_reg ? mem_rd_data : 8'h00;
                res_item.read_ok          = read_ok_reg;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // datapath register updates
    always_comb
    begin
        load_count_next   = load_count_reg;
        out_length_next   = out_length_reg;
        last_status_next  = last_status_reg;
        boundary_pos_next = boundary_pos_reg;
        first_byte_next   = first_byte_reg;
        base_next         = base_reg;
        len_next          = len_reg;
        tail_byte_next    = tail_byte_reg;
        pos_next          = pos_reg;
        pairs_next        = pairs_reg;
        hi_byte_next      = hi_byte_reg;
        found_next        = found_reg;
        x_next            = x_reg;
        bnd_next          = bnd_reg;
        pad_next          = pad_reg;
        read_ok_next      = read_ok_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && is_load)
                begin
                    if (load_count_reg == '0)
                    begin
                        out_length_next = '0;
                        first_byte_next = req_item.data_in;
                    end
                    load_count_next = lc_inc;
                    if (req_item.is_last)
                    begin
                        load_count_next = '0;
                        base_next       = lead_zero;
                        len_next        = len_start;
                        if (len_start == '0)
                        begin
                            last_status_next = ST_LENGTH;
                        end
                    end
                end
                else if (req_fire && is_read)
                begin
                    read_ok_next = read_ok_now;
                end
            end
            S_TAIL_CHK:
            begin
                tail_byte_next = mem_rd_data;
                if (nib_bad)
                begin
                    last_status_next = ST_NIBBLE;
                end
                else if (len_short)
                begin
                    last_status_next = ST_LENGTH;
                end
            end
            S_TAIL_FIX:
            begin
                pos_next   = AW'(len_reg - CW'(1));
                pairs_next = t_val;
                found_next = 1'b0;
                bnd_next   = '0;
            end
            S_SCAN_LO:
            begin
                hi_byte_next = mem_rd_data;
            end
            S_SCAN_CHK:
            begin
                if (hit)
                begin
                    if (found_reg)
                    begin
                        last_status_next = ST_SECOND;
                    end
                    else
                    begin
                        found_next = 1'b1;
                        x_next     = x_now;
                        bnd_next   = pos_reg - AW'(1);
                    end
                end
                pos_next   = pos_reg - AW'(2);
                pairs_next = pairs_reg - T_W'(1);
            end
            S_FINISH:
            begin
                out_length_next   = rec_len_now;
                boundary_pos_next = AW'(base_reg) + bnd_reg;
                pad_next          = found_reg ? x_reg - 8'd1 : 8'h00;
                last_status_next  = ST_OK;
            end
            default:
            begin
                read_ok_next = read_ok_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            load_count_reg   <= '0;
            out_length_reg   <= '0;
            last_status_reg  <= ST_OK;
            boundary_pos_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            load_count_reg   <= load_count_next;
            out_length_reg   <= out_length_next;
            last_status_reg  <= last_status_next;
            boundary_pos_reg <= boundary_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_byte_reg <= first_byte_next;
        base_reg       <= base_next;
        len_reg        <= len_next;
        tail_byte_reg  <= tail_byte_next;
        pos_reg        <= pos_next;
        pairs_reg      <= pairs_next;
        hi_byte_reg    <= hi_byte_next;
        found_reg      <= found_next;
        x_reg          <= x_next;
        bnd_reg        <= bnd_next;
        pad_reg        <= pad_next;
        read_ok_reg    <= read_ok_next;
    end

endmodule

/* hdl/iso9796_1_pad_decoder.sv */
// Top level of the ISO 9796-1 pad decoder: config register, result register, store.
//
//   channel | dir | handshake            | carries
//   --------+-----+----------------------+---------------------------------------
//   cfg     | in  | cfg_valid/cfg_ready  | key_bits (modulus size, sets t)
//   req     | in  | req_valid/req_ready  | load byte (optionally last) or read
//   rsp     | out | rsp_valid/rsp_ready  | decode status or one recovered byte
//
// A plain load only writes the store. A read does one store read, then hands over the result.
// Last byte: the tail is read, checked and fixed, the first high byte is fetched, then each
// of the t = (key_bits + 13) / 16 byte pairs is read and checked, then the decode finishes
// and hands over the status; the steps are set by the single read port of the block store.
// Errors end the decode early. req_ready is low while a decode or read is in flight;
// the result register lets the next item in while a result waits on rsp_ready.
// Reset clears counters and status; the store itself is not cleared.
module iso9796_1_pad_decoder #(
    parameter int MAX_BLOCK_BYTES = 512
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ipd_pkg::KEY_W-1:0] cfg_data,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  ipd_pkg::ipd_req_t         req_item,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output ipd_pkg::ipd_rsp_t         rsp_item
);

    import ipd_pkg::*;

    localparam int AW = $clog2(MAX_BLOCK_BYTES);

    logic [KEY_W-1:0] key_bits_reg;
    logic             rsp_valid_reg;
    ipd_rsp_t         rsp_item_reg;

    logic          res_valid;
    logic          slot_free;
    ipd_rsp_t      res_item;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    // key_bits may be written at any time the block is idle
    assign cfg_ready = 1'b1;

    // result slot frees up in the same cycle the sink takes the item
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bits_reg  <= KEY_BITS_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_bits_reg <= cfg_data;
            end
            if (res_valid && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && slot_free)
        begin
            rsp_item_reg <= res_item;
        end
    end

    ipd_seq #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_item    (req_item),
        .key_bits    (key_bits_reg),
        .res_valid   (res_valid),
        .res_ready   (slot_free),
        .res_item    (res_item),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ipd_mem #(
        .DEPTH (MAX_BLOCK_BYTES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

/* hdl/ipd_checker.sv */
// Port-level checks for the pad decoder, bound to the top level.
module ipd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic                      req_valid,
    input logic                      req_ready,
    input ipd_pkg::ipd_req_t         req_item,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input ipd_pkg::ipd_rsp_t         rsp_item
);

    import ipd_pkg::*;

    logic req_fire;
    logic cfg_fire;

    assign req_fire = req_valid && req_ready;
    assign cfg_fire = cfg_valid && cfg_ready;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    // a read with an empty result slot answers through the store read and the result register, gated by length
    a_read_answer: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_item.req_type == REQ_READ && !rsp_valid && !cfg_fire |->
        ##2 (rsp_valid && rsp_item.result_kind == KIND_READ &&
             rsp_item.read_ok == ({1'b0, $past(req_item.read_index, 2)} <
                                  rsp_item.recovered_length)))
        else $error("read item not answered as expected");

    // a plain load gives no result
    a_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_item.req_type == REQ_LOAD && !req_item.is_last && !rsp_valid
        |=> !rsp_valid)
        else $error("result after a plain load");

    // the decode holds off new items after the last byte
    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_item.req_type == REQ_LOAD && req_item.is_last |=> !req_ready)
        else $error("item taken during decode");

endmodule

bind iso9796_1_pad_decoder ipd_checker u_ipd_checker (.*);
